/* src/qrt_pkg.sv */
`default_nettype none
package qrt_pkg;

   localparam int COEF_W     = 32;
   localparam int COEF_FRAC  = 16;
   localparam int DIR_W      = 16;
   localparam int DIR_FRAC   = 14;
   localparam int N_AXIS     = 3;
   localparam int VEC_W      = N_AXIS * DIR_W;
   localparam int PROD_W     = 2 * COEF_W;
   localparam int DPROD_W    = COEF_W + DIR_W;
   localparam int VPROD_W    = 2 * DIR_W;
   localparam int COL_SHIFT  = COEF_FRAC - DIR_FRAC;
   localparam int SUM_W      = COEF_W + 6;
   localparam int N_COEF     = 10;
   localparam int N_QUAD     = 6;
   localparam int N_RES      = 10;
   localparam int N_DIAG     = 3;
   localparam int N_SLOT     = 3 * N_DIAG;
   localparam int N_LIN      = 4;
   localparam int N_DIR      = 2;
   localparam int LIN_BASE   = 6;
   localparam int CONST_IDX  = 9;
   localparam int LIN_RES    = 6;
   localparam int CONST_RES  = 9;
   localparam int ONE_Q14    = 1 << DIR_FRAC;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = VEC_W;

   // vectors 0..2 are the basis columns, vector 3 is the shift
   localparam int RES_A [N_RES] = '{0, 1, 2, 0, 0, 1, 0, 1, 2, 3};
   localparam int RES_B [N_RES] = '{0, 1, 2, 1, 2, 2, 3, 3, 3, 3};
   localparam int PAIR_LO [N_DIAG] = '{0, 0, 1};
   localparam int PAIR_HI [N_DIAG] = '{1, 2, 2};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASIS_FIRST  = 3'd0,
      CSR_BASIS_SECOND = 3'd1,
      CSR_BASIS_THIRD  = 3'd2,
      CSR_CENTER_X     = 3'd3,
      CSR_CENTER_Y     = 3'd4,
      CSR_CENTER_Z     = 3'd5
   } csr_idx_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [DIR_W-1:0]  comp_type;
   typedef logic [VEC_W-1:0]         pvec_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      coef_type coef_xx;
      coef_type coef_yy;
      coef_type coef_zz;
      coef_type coef_xy;
      coef_type coef_xz;
      coef_type coef_yz;
      coef_type coef_x;
      coef_type coef_y;
      coef_type coef_z;
      coef_type coef_const;
      pvec_type dir_first;
      pvec_type dir_second;
   } req_type;

   typedef struct packed {
      coef_type out_xx;
      coef_type out_yy;
      coef_type out_zz;
      coef_type out_xy;
      coef_type out_xz;
      coef_type out_yz;
      coef_type out_x;
      coef_type out_y;
      coef_type out_z;
      coef_type out_const;
      pvec_type out_dir_first;
      pvec_type out_dir_second;
   } rsp_type;

   typedef struct packed {
      pvec_type [N_AXIS-1:0] basis;
      coef_type [N_AXIS-1:0] center;
   } cfg_type;

   function automatic comp_type comp(input pvec_type v, input int k);
      return comp_type'(v[k*DIR_W +: DIR_W]);
   endfunction

   function automatic coef_type widen(input comp_type c);
      coef_type w;
      w = coef_type'(c);
      return w <<< COL_SHIFT;
   endfunction

   // round half up, then arithmetic shift
   function automatic prod_type rnd_shr(input prod_type v, input int n);
      prod_type h;
      prod_type s;
      h = prod_type'(1) << (n - 1);
      s = v + h;
      return s >>> n;
   endfunction

   function automatic coef_type sat_coef(input prod_type v);
      logic [PROD_W-COEF_W:0] hi;
      hi = v[PROD_W-1:COEF_W-1];
      if ((&hi) || (~|hi)) return v[COEF_W-1:0];
      else if (v[PROD_W-1]) return {1'b1, {(COEF_W-1){1'b0}}};
      else return {1'b0, {(COEF_W-1){1'b1}}};
   endfunction

   function automatic comp_type sat_dir(input prod_type v);
      logic [PROD_W-DIR_W:0] hi;
      hi = v[PROD_W-1:DIR_W-1];
      if ((&hi) || (~|hi)) return v[DIR_W-1:0];
      else if (v[PROD_W-1]) return {1'b1, {(DIR_W-1){1'b0}}};
      else return {1'b0, {(DIR_W-1){1'b1}}};
   endfunction

   function automatic coef_type mulq(input coef_type a, input coef_type b);
      prod_type p;
      p = a * b;
      return sat_coef(rnd_shr(p, COEF_FRAC));
   endfunction

   // slot layout per result: diagonal, cross lo/hi, cross hi/lo
   function automatic int slot_coef(input int s);
      if (s < 2 * N_DIAG) return s;
      else return s - N_DIAG;
   endfunction

   function automatic int slot_u(input int s);
      if (s < N_DIAG) return s;
      else if (s < 2 * N_DIAG) return PAIR_LO[s-N_DIAG];
      else return PAIR_HI[s-2*N_DIAG];
   endfunction

   function automatic int slot_v(input int s);
      if (s < N_DIAG) return s;
      else if (s < 2 * N_DIAG) return PAIR_HI[s-N_DIAG];
      else return PAIR_LO[s-2*N_DIAG];
   endfunction

endpackage
`default_nettype wire

/* src/qrt_if.sv */
`default_nettype none
interface qrt_req_if;
   logic             valid;
   logic             ready;
   qrt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface qrt_rsp_if;
   logic             valid;
   logic             ready;
   qrt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/qrt_front.sv */
`default_nettype none
module qrt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire qrt_pkg::req_type   in_item,
   input  wire qrt_pkg::cfg_type   cfg,
   output logic                    out_valid,
   output qrt_pkg::coef_type       out_coef [qrt_pkg::N_COEF],
   output qrt_pkg::coef_type       out_shift [qrt_pkg::N_AXIS],
   output qrt_pkg::pvec_type       out_dir [qrt_pkg::N_DIR]
);

   qrt_pkg::pvec_type basis [qrt_pkg::N_AXIS];
   qrt_pkg::coef_type center [qrt_pkg::N_AXIS];
   qrt_pkg::pvec_type dir_src [qrt_pkg::N_DIR];

   logic valid1_ff, valid2_ff;
   qrt_pkg::coef_type coef1_in [qrt_pkg::N_COEF];
   qrt_pkg::coef_type coef1_ff [qrt_pkg::N_COEF];
   qrt_pkg::coef_type coef2_ff [qrt_pkg::N_COEF];
   logic signed [qrt_pkg::DPROD_W-1:0] dprod_in [qrt_pkg::N_AXIS][qrt_pkg::N_AXIS];
   logic signed [qrt_pkg::DPROD_W-1:0] dprod_ff [qrt_pkg::N_AXIS][qrt_pkg::N_AXIS];
   logic signed [qrt_pkg::VPROD_W-1:0]
      vprod_in [qrt_pkg::N_DIR][qrt_pkg::N_AXIS][qrt_pkg::N_AXIS];
   logic signed [qrt_pkg::VPROD_W-1:0]
      vprod_ff [qrt_pkg::N_DIR][qrt_pkg::N_AXIS][qrt_pkg::N_AXIS];
   qrt_pkg::coef_type shift_in [qrt_pkg::N_AXIS];
   qrt_pkg::coef_type shift_ff [qrt_pkg::N_AXIS];
   qrt_pkg::pvec_type dir_in [qrt_pkg::N_DIR];
   qrt_pkg::pvec_type dir_ff [qrt_pkg::N_DIR];

   always_comb begin
      for (int k = 0; k < qrt_pkg::N_AXIS; k++) begin
         basis[k]  = cfg.basis[k];
         center[k] = cfg.center[k];
      end
      dir_src[0] = in_item.dir_first;
      dir_src[1] = in_item.dir_second;
      coef1_in[0] = in_item.coef_xx;
      coef1_in[1] = in_item.coef_yy;
      coef1_in[2] = in_item.coef_zz;
      coef1_in[3] = in_item.coef_xy;
      coef1_in[4] = in_item.coef_xz;
      coef1_in[5] = in_item.coef_yz;
      coef1_in[6] = in_item.coef_x;
      coef1_in[7] = in_item.coef_y;
      coef1_in[8] = in_item.coef_z;
      coef1_in[9] = in_item.coef_const;
   end

   // stage 1: raw products for the shift and the direction rotation
   always_comb begin
      for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
         for (int k = 0; k < qrt_pkg::N_AXIS; k++) begin
            dprod_in[i][k] = center[k] * qrt_pkg::comp(basis[i], k);
         end
      end
      for (int d = 0; d < qrt_pkg::N_DIR; d++) begin
         for (int c = 0; c < qrt_pkg::N_AXIS; c++) begin
            for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
               vprod_in[d][c][i] = qrt_pkg::comp(dir_src[d], i) * qrt_pkg::comp(basis[i], c);
            end
         end
      end
   end

   // stage 2: sums, rounding and saturation
   always_comb begin
      qrt_pkg::prod_type acc;
      for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
         acc = qrt_pkg::prod_type'(dprod_ff[i][0]) + qrt_pkg::prod_type'(dprod_ff[i][1])
             + qrt_pkg::prod_type'(dprod_ff[i][2]);
         acc = -acc;
         shift_in[i] = qrt_pkg::sat_coef(qrt_pkg::rnd_shr(acc, qrt_pkg::DIR_FRAC));
      end
      for (int d = 0; d < qrt_pkg::N_DIR; d++) begin
         dir_in[d] = '0;
         for (int c = 0; c < qrt_pkg::N_AXIS; c++) begin
            acc = qrt_pkg::prod_type'(vprod_ff[d][c][0])
                + qrt_pkg::prod_type'(vprod_ff[d][c][1])
                + qrt_pkg::prod_type'(vprod_ff[d][c][2]);
            dir_in[d][c*qrt_pkg::DIR_W +: qrt_pkg::DIR_W] =
               qrt_pkg::sat_dir(qrt_pkg::rnd_shr(acc, qrt_pkg::DIR_FRAC));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coef1_ff <= coef1_in;
         dprod_ff <= dprod_in;
         vprod_ff <= vprod_in;
         coef2_ff <= coef1_ff;
         shift_ff <= shift_in;
         dir_ff   <= dir_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_coef  = coef2_ff;
   assign out_shift = shift_ff;
   assign out_dir   = dir_ff;

endmodule
`default_nettype wire

/* src/qrt_terms.sv */
`default_nettype none
module qrt_terms (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire qrt_pkg::coef_type  in_coef [qrt_pkg::N_COEF],
   input  wire qrt_pkg::coef_type  in_shift [qrt_pkg::N_AXIS],
   input  wire qrt_pkg::pvec_type  in_dir [qrt_pkg::N_DIR],
   input  wire qrt_pkg::cfg_type   cfg,
   output logic                    out_valid,
   output qrt_pkg::coef_type       out_term [qrt_pkg::N_RES][qrt_pkg::N_SLOT],
   output qrt_pkg::coef_type       out_lin [qrt_pkg::N_LIN][qrt_pkg::N_AXIS],
   output qrt_pkg::coef_type       out_const,
   output qrt_pkg::pvec_type       out_dir [qrt_pkg::N_DIR]
);

   qrt_pkg::coef_type vecs [qrt_pkg::N_LIN][qrt_pkg::N_AXIS];

   logic valid3_ff, valid4_ff;
   qrt_pkg::coef_type inner_in [qrt_pkg::N_RES][qrt_pkg::N_SLOT];
   qrt_pkg::coef_type inner_ff [qrt_pkg::N_RES][qrt_pkg::N_SLOT];
   qrt_pkg::coef_type outer_in [qrt_pkg::N_RES][qrt_pkg::N_SLOT];
   qrt_pkg::coef_type outer_ff [qrt_pkg::N_RES][qrt_pkg::N_SLOT];
   qrt_pkg::coef_type lin_in [qrt_pkg::N_LIN][qrt_pkg::N_AXIS];
   qrt_pkg::coef_type lin3_ff [qrt_pkg::N_LIN][qrt_pkg::N_AXIS];
   qrt_pkg::coef_type lin4_ff [qrt_pkg::N_LIN][qrt_pkg::N_AXIS];
   qrt_pkg::coef_type quad_in [qrt_pkg::N_QUAD];
   qrt_pkg::coef_type quad_ff [qrt_pkg::N_QUAD];
   qrt_pkg::coef_type const3_ff, const4_ff;
   qrt_pkg::pvec_type dir3_ff [qrt_pkg::N_DIR];
   qrt_pkg::pvec_type dir4_ff [qrt_pkg::N_DIR];

   // stage 3: products of vector components, and linear terms
   always_comb begin
      for (int c = 0; c < qrt_pkg::N_AXIS; c++) begin
         for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
            vecs[c][i] = qrt_pkg::widen(qrt_pkg::comp(cfg.basis[i], c));
         end
      end
      for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
         vecs[qrt_pkg::N_LIN-1][i] = in_shift[i];
      end
      for (int r = 0; r < qrt_pkg::N_RES; r++) begin
         for (int s = 0; s < qrt_pkg::N_SLOT; s++) begin
            inner_in[r][s] = qrt_pkg::mulq(vecs[qrt_pkg::RES_A[r]][qrt_pkg::slot_u(s)],
                                           vecs[qrt_pkg::RES_B[r]][qrt_pkg::slot_v(s)]);
         end
      end
      for (int l = 0; l < qrt_pkg::N_LIN; l++) begin
         for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
            lin_in[l][i] = qrt_pkg::mulq(in_coef[qrt_pkg::LIN_BASE+i], vecs[l][i]);
         end
      end
      for (int q = 0; q < qrt_pkg::N_QUAD; q++) begin
         quad_in[q] = in_coef[q];
      end
   end

   // stage 4: scale by the surface coefficient
   always_comb begin
      for (int r = 0; r < qrt_pkg::N_RES; r++) begin
         for (int s = 0; s < qrt_pkg::N_SLOT; s++) begin
            outer_in[r][s] = qrt_pkg::mulq(quad_ff[qrt_pkg::slot_coef(s)], inner_ff[r][s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (advance) begin
         valid3_ff <= in_valid;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inner_ff  <= inner_in;
         lin3_ff   <= lin_in;
         quad_ff   <= quad_in;
         const3_ff <= in_coef[qrt_pkg::CONST_IDX];
         dir3_ff   <= in_dir;
         outer_ff  <= outer_in;
         lin4_ff   <= lin3_ff;
         const4_ff <= const3_ff;
         dir4_ff   <= dir3_ff;
      end
   end

   assign out_valid = valid4_ff;
   assign out_term  = outer_ff;
   assign out_lin   = lin4_ff;
   assign out_const = const4_ff;
   assign out_dir   = dir4_ff;

endmodule
`default_nettype wire

/* src/qrt_reduce.sv */
`default_nettype none
module qrt_reduce (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire qrt_pkg::coef_type  in_term [qrt_pkg::N_RES][qrt_pkg::N_SLOT],
   input  wire qrt_pkg::coef_type  in_lin [qrt_pkg::N_LIN][qrt_pkg::N_AXIS],
   input  wire qrt_pkg::coef_type  in_const,
   input  wire qrt_pkg::pvec_type  in_dir [qrt_pkg::N_DIR],
   output logic                    out_valid,
   output qrt_pkg::rsp_type        out_item
);

   logic valid5_ff, valid6_ff;
   qrt_pkg::sum_type sum_a_in [qrt_pkg::N_RES];
   qrt_pkg::sum_type sum_a_ff [qrt_pkg::N_RES];
   qrt_pkg::sum_type sum_b_in [qrt_pkg::N_RES];
   qrt_pkg::sum_type sum_b_ff [qrt_pkg::N_RES];
   qrt_pkg::pvec_type dir5_ff [qrt_pkg::N_DIR];
   qrt_pkg::coef_type res [qrt_pkg::N_RES];
   qrt_pkg::rsp_type out_in, out_ff;

   // stage 5: two partial sums per result
   always_comb begin
      logic same;
      for (int r = 0; r < qrt_pkg::N_RES; r++) begin
         same = (qrt_pkg::RES_A[r] == qrt_pkg::RES_B[r]);
         sum_a_in[r] = '0;
         sum_b_in[r] = '0;
         for (int s = 0; s < qrt_pkg::N_DIAG; s++) begin
            // diagonal terms count twice in a mixed form
            sum_a_in[r] = sum_a_in[r] + (same ? qrt_pkg::sum_type'(in_term[r][s])
                                              : qrt_pkg::sum_type'(in_term[r][s]) <<< 1);
            sum_a_in[r] = sum_a_in[r] + qrt_pkg::sum_type'(in_term[r][s+qrt_pkg::N_DIAG]);
            if (!same) begin
               sum_b_in[r] = sum_b_in[r] + qrt_pkg::sum_type'(in_term[r][s+2*qrt_pkg::N_DIAG]);
            end
         end
      end
      for (int r = qrt_pkg::LIN_RES; r < qrt_pkg::N_RES; r++) begin
         for (int i = 0; i < qrt_pkg::N_AXIS; i++) begin
            sum_b_in[r] = sum_b_in[r] + qrt_pkg::sum_type'(in_lin[r-qrt_pkg::LIN_RES][i]);
         end
      end
      sum_b_in[qrt_pkg::CONST_RES] = sum_b_in[qrt_pkg::CONST_RES]
                                   + qrt_pkg::sum_type'(in_const);
   end

   // stage 6: final add and saturation into the output register
   always_comb begin
      for (int r = 0; r < qrt_pkg::N_RES; r++) begin
         res[r] = qrt_pkg::sat_coef(qrt_pkg::prod_type'(sum_a_ff[r] + sum_b_ff[r]));
      end
      out_in.out_xx         = res[0];
      out_in.out_yy         = res[1];
      out_in.out_zz         = res[2];
      out_in.out_xy         = res[3];
      out_in.out_xz         = res[4];
      out_in.out_yz         = res[5];
      out_in.out_x          = res[6];
      out_in.out_y          = res[7];
      out_in.out_z          = res[8];
      out_in.out_const      = res[9];
      out_in.out_dir_first  = dir5_ff[0];
      out_in.out_dir_second = dir5_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else if (advance) begin
         valid5_ff <= in_valid;
         valid6_ff <= valid5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         dir5_ff  <= in_dir;
         out_ff   <= out_in;
      end
   end

   assign out_valid = valid6_ff;
   assign out_item  = out_ff;

endmodule
`default_nettype wire

/* src/quadric_rigid_transform_core.sv */
// Quadric rigid transform: rewrites a quadric's ten coefficients for a moved surface
// and rotates its two direction vectors. Six register stages lie between an input
// transfer and the result register from which its result transfers.
// Throughput one item per cycle; the whole pipeline holds while the result waits.
// Synchronous active-high reset clears all valid bits and loads the identity basis
// and a zero center; no result is pending after reset.
`default_nettype none
module quadric_rigid_transform_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   qrt_req_if.sink                                req,
   qrt_rsp_if.source                              rsp,
   input  wire logic                              csr_write_enable,
   input  wire logic [qrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [qrt_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   qrt_pkg::pvec_type basis_in [qrt_pkg::N_AXIS];
   qrt_pkg::pvec_type basis_ff [qrt_pkg::N_AXIS];
   qrt_pkg::coef_type center_in [qrt_pkg::N_AXIS];
   qrt_pkg::coef_type center_ff [qrt_pkg::N_AXIS];
   qrt_pkg::cfg_type  cfg;

   logic advance;
   logic front_valid, terms_valid, rsp_valid;
   qrt_pkg::coef_type front_coef [qrt_pkg::N_COEF];
   qrt_pkg::coef_type front_shift [qrt_pkg::N_AXIS];
   qrt_pkg::pvec_type front_dir [qrt_pkg::N_DIR];
   qrt_pkg::coef_type terms_term [qrt_pkg::N_RES][qrt_pkg::N_SLOT];
   qrt_pkg::coef_type terms_lin [qrt_pkg::N_LIN][qrt_pkg::N_AXIS];
   qrt_pkg::coef_type terms_const;
   qrt_pkg::pvec_type terms_dir [qrt_pkg::N_DIR];
   qrt_pkg::rsp_type  rsp_item;

   always_comb begin
      basis_in  = basis_ff;
      center_in = center_ff;
      if (csr_write_enable) begin
         case (qrt_pkg::csr_idx_type'(csr_index))
            qrt_pkg::CSR_BASIS_FIRST:  basis_in[0]  = csr_write_data;
            qrt_pkg::CSR_BASIS_SECOND: basis_in[1]  = csr_write_data;
            qrt_pkg::CSR_BASIS_THIRD:  basis_in[2]  = csr_write_data;
            qrt_pkg::CSR_CENTER_X:     center_in[0] = csr_write_data[qrt_pkg::COEF_W-1:0];
            qrt_pkg::CSR_CENTER_Y:     center_in[1] = csr_write_data[qrt_pkg::COEF_W-1:0];
            qrt_pkg::CSR_CENTER_Z:     center_in[2] = csr_write_data[qrt_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < qrt_pkg::N_AXIS; k++) begin
            basis_ff[k]  <= qrt_pkg::pvec_type'(qrt_pkg::ONE_Q14) << (k * qrt_pkg::DIR_W);
            center_ff[k] <= '0;
         end
      end else begin
         basis_ff  <= basis_in;
         center_ff <= center_in;
      end
   end

   always_comb begin
      for (int k = 0; k < qrt_pkg::N_AXIS; k++) begin
         cfg.basis[k]  = basis_ff[k];
         cfg.center[k] = center_ff[k];
      end
   end

   // one enable for every stage: move unless the result register is blocked
   assign advance   = !rsp_valid || rsp.ready;
   assign req.ready = advance;

   qrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .in_item   (req.payload),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_coef  (front_coef),
      .out_shift (front_shift),
      .out_dir   (front_dir)
   );

   qrt_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_coef   (front_coef),
      .in_shift  (front_shift),
      .in_dir    (front_dir),
      .cfg       (cfg),
      .out_valid (terms_valid),
      .out_term  (terms_term),
      .out_lin   (terms_lin),
      .out_const (terms_const),
      .out_dir   (terms_dir)
   );

   qrt_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (terms_valid),
      .in_term   (terms_term),
      .in_lin    (terms_lin),
      .in_const  (terms_const),
      .in_dir    (terms_dir),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   assign rsp.valid   = rsp_valid;
   assign rsp.payload = rsp_item;

endmodule
`default_nettype wire

/* src/qrt_checker.sv */
`default_nettype none
module qrt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire qrt_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline is stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind quadric_rigid_transform_core qrt_checker u_qrt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
`default_nettype wire
